>>> hw/rtl/timestamped_history_interpolator_unit_assert.svh
// assertion macros used by the checker file
`ifndef TIMESTAMPED_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`define TIMESTAMPED_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define THI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define THI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/thi_pkg.sv
// types, constants and codes of the history interpolator
`timescale 1ns / 1ps
`default_nettype none
package thi_pkg;
  localparam int DEPTH     = 32;
  localparam int FRAC_BITS = 16;
  localparam int NVAL      = 6;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int REG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_OVERWRITE = 2'd1,
    CMD_READ      = 2'd2,
    CMD_CLEAR     = 2'd3
  } thi_cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WRITE_INTERVAL = 1'b0,
    REG_HISTORY_LENGTH = 1'b1
  } thi_reg_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_DIV,
    ST_MUL,
    ST_OUT,
    ST_PUSH
  } thi_state_t;

  typedef struct packed {
    logic [31:0]            etime;
    logic [NVAL-1:0][31:0]  val;
  } entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/timestamped_history_interpolator_unit.sv
// Timestamped snapshot history with linear interpolation on read.
// Input channel in_valid/in_ready takes one command item (write, overwrite,
// read, clear) with its time and six Q16.16 values. Only a read gives a
// result item on out_valid/out_ready; the others give none.
// Configuration writes arrive on cfg_valid/cfg_ready (always ready),
// cfg_index 0 is write_interval, 1 is history_length.
// Entries sit in a ring of 32 cells, newest in cell 0. Write and clear
// finish in the accepting cycle, so they can follow back to back. Overwrite
// and read of a non-empty history rotate the ring once round to search from
// newest to oldest; an overwrite that appends pushes its entry after the
// search. A read then selects and, when it interpolates, runs the serial
// fraction divider and the shared multiplier on each of the six values; it
// takes no new item until its result goes to the result register. A read
// of an empty history skips the search and goes straight to the output
// state. Reset empties the history and sets write_interval 16 and
// history_length 32. A stalled receiver holds the result; the block sits
// in its output state until the result register is free again.
`timescale 1ns / 1ps
`default_nettype none
module timestamped_history_interpolator_unit import thi_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            command,
  input  wire logic [31:0]           stamp_time,
  input  wire logic [31:0]           now_time,
  input  wire logic signed [31:0]    pos_x,
  input  wire logic signed [31:0]    pos_y,
  input  wire logic signed [31:0]    pos_z,
  input  wire logic signed [31:0]    vel_x,
  input  wire logic signed [31:0]    vel_y,
  input  wire logic signed [31:0]    vel_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_pos_z,
  output logic signed [31:0]         out_vel_x,
  output logic signed [31:0]         out_vel_y,
  output logic signed [31:0]         out_vel_z,
  output logic                       from_history,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]           cfg_data
);
  localparam int PROD_W = 33 + FRAC_W + 1;

  thi_state_t state, state_next;
  cell_op_t   cell_op;
  entry_t     cq [DEPTH];
  entry_t     push_data, wrap_data, port_e, in_q;

  thi_cmd_t              cmd_q;
  logic [31:0]           when_q, now_q;
  logic [15:0]           wi;
  logic [5:0]            hl;
  logic [CNT_W-1:0]      cnt, cnt_app, eff_len;
  logic [IDX_W-1:0]      j;
  logic                  found, app_pend, hist;
  logic [NVAL-1:0][31:0] a_val, b_val, res, out_val;
  logic [31:0]           num, den;
  logic [FRAC_W-1:0]     f, div_frac;
  logic                  div_start, div_done;
  logic [2:0]            lane;
  logic                  phase;
  logic signed [PROD_W-1:0] prod;
  logic signed [32:0]    diff;
  logic signed [PROD_W-1:0] prod_sh;

  logic examine, hit, last, gap_idle, gap_scan;

  assign port_e = '{etime: stamp_time,
                    val: {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x}};

  assign cfg_ready = 1'b1;

  always_comb begin
    if (hl == 6'd0)
      eff_len = CNT_W'(1);
    else if (int'(hl) > DEPTH)
      eff_len = CNT_W'(DEPTH);
    else
      eff_len = CNT_W'(hl);
  end

  // oldest drops once the length is reached, so the count stays
  assign cnt_app = (cnt != '0 && cnt >= eff_len) ? cnt : cnt + CNT_W'(1);

  assign examine  = (CNT_W'(j) < cnt) && !found;
  assign hit      = when_q >= cq[0].etime;
  assign last     = j == IDX_W'(DEPTH - 1);
  assign gap_idle = (stamp_time - cq[0].etime) >= {16'd0, wi};
  assign gap_scan = (when_q - cq[0].etime) >= {16'd0, wi};

  // ring of cells: push moves toward the tail, rotate moves toward cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    thi_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .from_prev ((g == 0) ? push_data : cq[(g == 0) ? 0 : g - 1]),
      .from_next ((g == DEPTH - 1) ? wrap_data : cq[(g == DEPTH - 1) ? 0 : g + 1]),
      .q         (cq[g])
    );
  end

  thi_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .frac  (div_frac)
  );

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    cell_op    = CELL_HOLD;
    push_data  = in_q;
    wrap_data  = cq[0];
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        push_data = port_e;
        if (in_valid) begin
          case (thi_cmd_t'(command))
            CMD_WRITE: begin
              if (cnt == '0 || gap_idle)
                cell_op = CELL_PUSH;
            end
            CMD_OVERWRITE: begin
              if (cnt == '0)
                cell_op = CELL_PUSH;
              else
                state_next = ST_SCAN;
            end
            CMD_READ: state_next = (cnt == '0) ? ST_OUT : ST_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cell_op = CELL_ROT;
        // replace the matched entry as it wraps round
        if (examine && hit && cmd_q == CMD_OVERWRITE && !(j == '0 && gap_scan))
          wrap_data = in_q;
        if (last) begin
          if (cmd_q == CMD_OVERWRITE)
            state_next = app_pend ? ST_PUSH : ST_IDLE;
          else
            state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        if (found && hist) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done)
          state_next = ST_MUL;
      end
      ST_MUL: begin
        if (phase && lane == 3'(NVAL - 1))
          state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready)
          state_next = ST_IDLE;
      end
      ST_PUSH: begin
        cell_op    = CELL_PUSH;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign diff    = $signed({b_val[lane][31], b_val[lane]})
                 - $signed({a_val[lane][31], a_val[lane]});
  assign prod_sh = prod >>> FRAC_BITS;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      wi        <= 16'd16;
      hl        <= 6'd32;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (thi_reg_t'(cfg_index))
          REG_WRITE_INTERVAL: wi <= cfg_data;
          REG_HISTORY_LENGTH: hl <= cfg_data[5:0];
          default: wi <= wi;
        endcase
      end
      if (out_valid && out_ready)
        out_valid <= 1'b0;
      if (state == ST_OUT && (!out_valid || out_ready))
        out_valid <= 1'b1;
      if (cell_op == CELL_PUSH)
        cnt <= cnt_app;
      else if (state == ST_IDLE && in_valid && thi_cmd_t'(command) == CMD_CLEAR)
        cnt <= '0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_q    <= thi_cmd_t'(command);
          when_q   <= stamp_time;
          now_q    <= now_time;
          in_q     <= port_e;
          j        <= '0;
          found    <= 1'b0;
          app_pend <= 1'b0;
          hist     <= 1'b0;
          res      <= port_e.val;
        end
      end
      ST_SCAN: begin
        j <= j + IDX_W'(1);
        if (examine) begin
          a_val <= cq[0].val;
          if (hit) begin
            found <= 1'b1;
            num   <= when_q - cq[0].etime;
            if (cmd_q == CMD_OVERWRITE && j == '0 && gap_scan)
              app_pend <= 1'b1;
            if (j == '0) begin
              // newest entry: head toward the current values
              if (now_q > cq[0].etime) begin
                hist  <= 1'b1;
                b_val <= in_q.val;
                den   <= now_q - cq[0].etime;
              end
            end else begin
              hist  <= 1'b1;
              b_val <= cq[DEPTH-1].val;
              den   <= cq[DEPTH-1].etime - cq[0].etime;
            end
          end
        end
      end
      ST_SEL: begin
        if (!found) begin
          res  <= a_val;
          hist <= 1'b1;
        end
        lane  <= '0;
        phase <= 1'b0;
      end
      ST_DIV: begin
        if (div_done)
          f <= div_frac;
      end
      ST_MUL: begin
        if (!phase) begin
          prod  <= diff * $signed({1'b0, f});
          phase <= 1'b1;
        end else begin
          res[lane] <= a_val[lane] + prod_sh[31:0];
          lane      <= lane + 3'd1;
          phase     <= 1'b0;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_val      <= res;
          from_history <= hist;
        end
      end
      default: j <= j;
    endcase
  end

  assign out_pos_x = out_val[0];
  assign out_pos_y = out_val[1];
  assign out_pos_z = out_val[2];
  assign out_vel_x = out_val[3];
  assign out_vel_y = out_val[4];
  assign out_vel_z = out_val[5];
endmodule
`default_nettype wire

>>> hw/rtl/thi_cell.sv
// one history cell: holds an entry, takes a new one or its neighbor's
`timescale 1ns / 1ps
`default_nettype none
module thi_cell import thi_pkg::*; (
  input  wire logic     clk,
  input  wire cell_op_t op,
  input  wire entry_t   from_prev,
  input  wire entry_t   from_next,
  output entry_t        q
);
  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH: q <= from_prev;
      CELL_ROT:  q <= from_next;
      default:   q <= q;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/thi_frac_div.sv
// serial restoring divider for the interpolation fraction
`timescale 1ns / 1ps
`default_nettype none
module thi_frac_div import thi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       num,
  input  wire logic [31:0]       den,
  output logic                   done,
  output logic [FRAC_W-1:0]      frac
);
  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [32:0]       rem;
  logic [31:0]       dvs;
  logic [32:0]       rem_sh;

  assign rem_sh = {rem[31:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'd0 || num >= den) begin
          frac <= FRAC_W'(1) << FRAC_BITS;
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          rem   <= {1'b0, num};
          dvs   <= den;
          frac  <= '0;
          steps <= STEP_W'(FRAC_BITS);
        end
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem  <= rem_sh - {1'b0, dvs};
          frac <= {frac[FRAC_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          frac <= {frac[FRAC_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/thi_checker.sv
// port-level checks of the history interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "timestamped_history_interpolator_unit_assert.svh"
module thi_checker import thi_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        command,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [31:0]       out_pos_x,
  input wire logic              from_history
);
  // a stalled result stays put
`THI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(from_history))
  // a read keeps the block busy past the accepting cycle
`THI_ASSERT_NEXT(a_read_busy, in_valid && in_ready && command == CMD_READ, !in_ready)
  // clear finishes at once
`THI_ASSERT_NEXT(a_clear_fast, in_valid && in_ready && command == CMD_CLEAR, in_ready)
endmodule

bind timestamped_history_interpolator_unit thi_checker u_thi_checker (.*);
`default_nettype wire
